// File: sv/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

	// Default table size and count width
	localparam int MAX_SUM_DEF    = 1024;
	localparam int COUNT_BITS_DEF = 32;

	// Fixed port field widths
	localparam int VALUE_W  = 11;
	localparam int TARGET_W = 11;
	localparam int OUT_W    = 32;

	// Depth of the command queue between front and engine (power of two)
	localparam int CMD_DEPTH = 2;

	// One classified request as it travels from front to engine
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               upd;
		logic               last;
	} cmd_t;

	// Engine status seen by the top level
	typedef struct packed {
		logic clearing;
		logic res_load;
	} stat_t;

endpackage

`default_nettype wire

// File: sv/subset_sum_counter.sv
// Subset-sum counter. Push a set of positive values, one per request, with
// last_item set on the final one; one result then appears on the output
// queue: the number of nonempty subsets of the set whose sum equals
// target_sum (clamped to MAX_SUM), saturating, with saturated set when a
// count at or below the target hit the ceiling or the result was clipped to
// 32 bits. A zero target gives zero. Values of zero or above MAX_SUM change
// nothing. A front stage takes requests into a two-entry command queue; the
// engine behind it keeps one count per partial sum in a single RAM and
// updates it from the top sum down, one entry per cycle. An item with value
// v occupies the engine while it walks the sums from MAX_SUM down to v and
// drains, a zero or oversized one only while it is taken; a last item then
// reads out the result, waits while the previous result still waits on the
// output, and then runs a table clearing pass, one RAM entry per cycle. The same
// clearing pass runs after reset, and no request is taken from the queue while it runs.
// Write target_sum only while the block is idle.
`default_nettype none

module subset_sum_counter #(
	parameter int MAX_SUM    = ssc_pkg::MAX_SUM_DEF,
	parameter int COUNT_BITS = ssc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         target_sum_we,
	input  wire logic [ssc_pkg::TARGET_W-1:0] target_sum,
	// requests in
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [ssc_pkg::VALUE_W-1:0]  item_value,
	input  wire logic                         last_item,
	// results out
	output logic                              empty,
	input  wire logic                         pop,
	output logic      [ssc_pkg::OUT_W-1:0]    subset_count,
	output logic                              saturated
);

	localparam int AW = $clog2(MAX_SUM + 1);

	logic [ssc_pkg::TARGET_W-1:0] target_q;
	logic [AW-1:0]                tgt_eff;
	logic                         cmd_valid;
	logic                         cmd_ready;
	ssc_pkg::cmd_t                cmd;
	ssc_pkg::stat_t               stat;

	// Hold the target register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_sum_we) begin
			target_q <= target_sum;
		end
	end

	// Clamp the target to the table size
	assign tgt_eff = (int'(target_q) > MAX_SUM) ? AW'(MAX_SUM) : AW'(target_q);

	ssc_front #(
		.MAX_SUM (MAX_SUM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item_value (item_value),
		.last_item  (last_item),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	ssc_engine #(
		.MAX_SUM    (MAX_SUM),
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.tgt          (tgt_eff),
		.empty        (empty),
		.pop          (pop),
		.subset_count (subset_count),
		.saturated    (saturated),
		.stat         (stat)
	);

`ifndef SYNTHESIS
	// A full command queue always offers a request to the engine
	a_full_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cmd_valid)
		else $error("command queue full with no request offered");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_load |-> (empty || pop))
		else $error("result loaded over a pending result");

	// Every delivered result is followed by the table clearing pass
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		stat.res_load |=> stat.clearing)
		else $error("table not cleared after a result");

	// The engine takes no request while the table is being cleared
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !cmd_ready)
		else $error("request taken during clearing pass");
`endif

endmodule

`default_nettype wire

// File: sv/ssc_ram.sv
`default_nettype none

module ssc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1025
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// File: sv/ssc_front.sv
`default_nettype none

module ssc_front #(
	parameter int MAX_SUM = ssc_pkg::MAX_SUM_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [ssc_pkg::VALUE_W-1:0] item_value,
	input  wire logic                        last_item,
	output logic                             cmd_valid,
	input  wire logic                        cmd_ready,
	output ssc_pkg::cmd_t                    cmd
);

	localparam int PTR_W = $clog2(ssc_pkg::CMD_DEPTH);
	localparam int CNT_W = $clog2(ssc_pkg::CMD_DEPTH + 1);

	ssc_pkg::cmd_t    slot_q [ssc_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push_ok;
	logic             pop_ok;
	ssc_pkg::cmd_t    new_cmd;

	assign full      = (cnt_q == CNT_W'(ssc_pkg::CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_valid && cmd_ready;

	// Classify: zero or out-of-table values leave the table alone
	always_comb begin
		new_cmd.value = item_value;
		new_cmd.upd   = (item_value != '0) && (int'(item_value) <= MAX_SUM);
		new_cmd.last  = last_item;
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_ok) - CNT_W'(pop_ok);
		end
	end

endmodule

`default_nettype wire

// File: sv/ssc_engine.sv
`default_nettype none

module ssc_engine #(
	parameter int MAX_SUM    = ssc_pkg::MAX_SUM_DEF,
	parameter int COUNT_BITS = ssc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cmd_valid,
	output logic                                    cmd_ready,
	input  wire ssc_pkg::cmd_t                      cmd,
	input  wire logic [$clog2(MAX_SUM + 1)-1:0]     tgt,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic      [ssc_pkg::OUT_W-1:0]          subset_count,
	output logic                                    saturated,
	output ssc_pkg::stat_t                          stat
);

	localparam int AW    = $clog2(MAX_SUM + 1);
	localparam int OUT_W = ssc_pkg::OUT_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_DRAIN,
		ST_RES_RD,
		ST_RES
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_addr_q;
	logic [AW-1:0]         s_q;
	logic [AW-1:0]         v_q;
	logic                  last_q;
	logic                  overflow_q;
	logic                  upd_vld_s1;
	logic [AW-1:0]         upd_addr_s1;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      count_q;
	logic                  sat_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [AW-1:0]         raddr_a;
	logic [AW-1:0]         raddr_b;
	logic [COUNT_BITS-1:0] rd_a;
	logic [COUNT_BITS-1:0] rd_b;
	logic [COUNT_BITS:0]   add_sum;
	logic                  add_carry;
	logic                  out_free;
	logic                  res_load;
	logic                  clip;
	logic [OUT_W-1:0]      cnt_out;
	logic [OUT_W-1:0]      res_count;
	logic                  res_sat;

	ssc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_SUM + 1)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	assign add_sum   = {1'b0, rd_a} + {1'b0, rd_b};
	assign add_carry = add_sum[COUNT_BITS];

	// Read port a walks the sums during an update, else points at the target
	assign raddr_a = (state_q == ST_UPD) ? s_q : tgt;
	assign raddr_b = s_q - v_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = upd_addr_s1;
		ram_wdata = add_carry ? '1 : add_sum[COUNT_BITS-1:0];
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = (clr_addr_q == '0) ? COUNT_BITS'(1) : '0;
		end else if (upd_vld_s1) begin
			ram_we = 1'b1;
		end
	end

	// Clip a wide count to the result width
	generate
		if (COUNT_BITS > OUT_W) begin : g_clip
			assign clip    = |rd_a[COUNT_BITS-1:OUT_W];
			assign cnt_out = clip ? '1 : rd_a[OUT_W-1:0];
		end else begin : g_ext
			assign clip    = 1'b0;
			assign cnt_out = OUT_W'(rd_a);
		end
	endgenerate

	assign res_count = (tgt == '0) ? '0 : cnt_out;
	assign res_sat   = (tgt == '0) ? 1'b0 : (overflow_q || clip);

	assign out_free  = !out_valid_q || pop;
	assign res_load  = (state_q == ST_RES) && out_free;
	assign cmd_ready = (state_q == ST_IDLE);

	assign empty        = !out_valid_q;
	assign subset_count = count_q;
	assign saturated    = sat_q;

	always_comb begin
		stat.clearing = (state_q == ST_CLEAR);
		stat.res_load = res_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			s_q         <= '0;
			v_q         <= '0;
			last_q      <= 1'b0;
			overflow_q  <= 1'b0;
			upd_vld_s1  <= 1'b0;
			upd_addr_s1 <= '0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			sat_q       <= 1'b0;
		end else begin
			upd_vld_s1  <= (state_q == ST_UPD);
			upd_addr_s1 <= s_q;
			if (upd_vld_s1 && add_carry && (upd_addr_s1 <= tgt)) begin
				overflow_q <= 1'b1;
			end

			if (res_load) begin
				out_valid_q <= 1'b1;
				count_q     <= res_count;
				sat_q       <= res_sat;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == AW'(MAX_SUM)) begin
						clr_addr_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						v_q    <= AW'(cmd.value);
						last_q <= cmd.last;
						s_q    <= AW'(MAX_SUM);
						if (cmd.upd) begin
							state_q <= ST_UPD;
						end else if (cmd.last) begin
							state_q <= ST_RES_RD;
						end
					end
				end
				ST_UPD: begin
					if (s_q == v_q) begin
						state_q <= ST_DRAIN;
					end else begin
						s_q <= s_q - AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= last_q ? ST_RES_RD : ST_IDLE;
				end
				ST_RES_RD: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (out_free) begin
						overflow_q <= 1'b0;
						state_q    <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
